>>> sv/emp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package emp_pkg;
   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 10;
   localparam int OUT_TIME_W = 32;
   localparam int MAG_W      = 41;

   localparam logic [63:0]      VSQ_EPS = 64'd4;
   localparam logic [MAG_W-1:0] MAG_CAP = 41'h100_0000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] rel_pos_x;
      logic signed [COORD_W-1:0] rel_pos_y;
      logic signed [COORD_W-1:0] rel_pos_z;
      logic signed [COORD_W-1:0] rel_vel_x;
      logic signed [COORD_W-1:0] rel_vel_y;
      logic signed [COORD_W-1:0] rel_vel_z;
      logic [INDEX_W-1:0]        first_index;
      logic [INDEX_W-1:0]        second_index;
      logic                      last_pair;
   } emp_req_type;

   typedef struct packed {
      logic                    pair_hit;
      logic [OUT_TIME_W-1:0]   pair_time;
      logic                    summary_valid;
      logic                    alarm;
      logic [OUT_TIME_W-1:0]   best_time;
      logic [INDEX_W-1:0]      best_first;
      logic [INDEX_W-1:0]      best_second;
   } emp_rsp_type;

   function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] x);
      mag32 = x[COORD_W-1] ? (~x + 32'd1) : x;
   endfunction
endpackage
`default_nettype wire

>>> sv/emp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module emp_mul (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [63:0] prod
);
   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(a) * 64'(b);
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

>>> sv/emp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module emp_div #(
   parameter int TIME_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [63:0]          num,
   input  wire logic [63:0]          den,
   output logic                      done,
   output logic      [TIME_BITS-1:0] quot
);
   localparam int NW    = 64 + FRAC_BITS;
   localparam int CW    = 64 + TIME_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(TIME_BITS + 1);

   logic [NW-1:0]        nwide;
   logic                 big;
   logic [64:0]          r2;
   logic                 qbit;
   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [63:0]          rem_ff;
   logic [63:0]          den_ff;
   logic [TIME_BITS-1:0] low_ff;
   logic [TIME_BITS-1:0] q_ff;

   always_comb begin
      nwide = {num, {FRAC_BITS{1'b0}}};
      big   = CW'(nwide) >= (CW'(den) << TIME_BITS);
      r2    = {rem_ff, low_ff[TIME_BITS-1]};
      qbit  = r2 >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff <= den;
            if (big) begin
               q_ff    <= '1;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= 64'(nwide >> TIME_BITS);
               low_ff  <= nwide[TIME_BITS-1:0];
               q_ff    <= '0;
               cnt_ff  <= CNT_W'(TIME_BITS);
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= qbit ? 64'(r2 - {1'b0, den_ff}) : r2[63:0];
            low_ff <= low_ff << 1;
            q_ff   <= {q_ff[TIME_BITS-2:0], qbit};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

>>> sv/earliest_proximity_alarm.sv
// Earliest proximity alarm: closest point of approach of moving point pairs.
// req_ channel: one item per pair (relative position/velocity, indices,
// last_pair flag); taken when req_valid is high and req_stall low. req_stall
// is high while an item is being worked on.
// rsp_ channel: one item per pair, held in an output register until taken;
// the next request is accepted while a result still waits under rsp_stall.
// csr_write/csr_data set safe_distance; write only while idle.
// Sequence: dot products on the shared 32x32 multiplier, the bit-serial
// divider for the closest time, then range evaluations (three axes, five
// steps each, stopping early once out of range): one at the closest time,
// one at time zero and up to TIME_BITS bisection trials (a trial not below
// the closest time is skipped without an evaluation).
// The next item is accepted in S_IDLE, after the result is written.
// The multiplier sequence sets the rate; one pair is in flight at a time.
// Reset (synchronous) clears safe_distance and the running minimum and drops
// any pending result. The minimum is cleared after each last_pair result.
`timescale 1ns / 1ps
`default_nettype none
module earliest_proximity_alarm #(
   parameter int TIME_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire emp_pkg::emp_req_type req_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output emp_pkg::emp_rsp_type      rsp_item,
   input  wire logic                 csr_write,
   input  wire logic [31:0]          csr_data
);
   import emp_pkg::*;

   localparam int BW = $clog2(TIME_BITS);

   typedef enum logic [2:0] {S_IDLE, S_DOT, S_DIV, S_DIVW, S_EVAL, S_BIS, S_FIN} state_type;
   typedef enum logic [1:0] {M_CPA, M_ZERO, M_BIS} mode_type;

   state_type            state_ff;
   mode_type             mode_ff;
   emp_req_type          item_ff;
   emp_rsp_type          rsp_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          safe_ff;
   logic [63:0]          ss_ff, vv_ff, pos_ff, neg_ff, lo_ff;
   logic                 pvs_ff;
   logic [2:0]           cnt_ff;
   logic [1:0]           ax_ff;
   logic [2:0]           ph_ff;
   logic [42:0]          ad_ff;
   logic [64:0]          sum_ff;
   logic [TIME_BITS-1:0] tc_ff, t_ff, g_ff, ht_ff;
   logic [BW-1:0]        bis_ff;
   logic                 hit_ff;
   logic                 found_ff;
   logic [31:0]          etime_ff;
   logic [INDEX_W-1:0]   efirst_ff, esecond_ff;

   logic [1:0]           sel_ax;
   logic [31:0]          cur_p, cur_v, pm, vm;
   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_p;
   logic [63:0]          t64;
   logic [64:0]          mt_hi;
   logic [96:0]          mts;
   logic [MAG_W-1:0]     m41;
   logic [42:0]          vt, psum, ad;
   logic [64:0]          acc;
   logic                 ev_done, ev_oor;
   logic                 div_start, div_done;
   logic [TIME_BITS-1:0] div_q, trial;
   logic [63:0]          ht64;
   logic [31:0]          ht32;
   logic                 upd;
   logic                 out_free;
   logic [2:0]           op;

   emp_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(mul_p));

   emp_div #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(neg_ff - pos_ff), .den(vv_ff), .done(div_done), .quot(div_q)
   );

   always_comb begin
      op     = cnt_ff - 3'd1;
      sel_ax = ax_ff;
      if (state_ff == S_DOT) begin
         sel_ax = (cnt_ff < 3'd3) ? cnt_ff[1:0] : 2'(cnt_ff - 3'd3);
      end
      case (sel_ax)
         2'd0: begin
            cur_p = item_ff.rel_pos_x;
            cur_v = item_ff.rel_vel_x;
         end
         2'd1: begin
            cur_p = item_ff.rel_pos_y;
            cur_v = item_ff.rel_vel_y;
         end
         default: begin
            cur_p = item_ff.rel_pos_z;
            cur_v = item_ff.rel_vel_z;
         end
      endcase
      pm  = mag32(cur_p);
      vm  = mag32(cur_v);
      t64 = 64'(t_ff);

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DOT: begin
            if (cnt_ff < 3'd3) begin
               mul_a = vm;
               mul_b = vm;
            end else if (cnt_ff < 3'd6) begin
               mul_a = pm;
               mul_b = vm;
            end else begin
               mul_a = safe_ff;
               mul_b = safe_ff;
            end
         end
         S_EVAL: begin
            if (ph_ff == 3'd0) begin
               mul_a = vm;
               mul_b = t64[31:0];
            end else if (ph_ff == 3'd1) begin
               mul_a = vm;
               mul_b = t64[63:32];
            end else if (ph_ff == 3'd3) begin
               mul_a = ad_ff[31:0];
               mul_b = ad_ff[31:0];
            end
         end
         default: ;
      endcase

      mt_hi = {1'b0, mul_p} + {33'b0, lo_ff[63:32]};
      mts   = {mt_hi[63:0], lo_ff[31:0], 1'b0} >> (FRAC_BITS + 1);
      m41   = (mts > 97'(MAG_CAP)) ? MAG_CAP : mts[MAG_W-1:0];
      vt    = cur_v[31] ? (~{2'b0, m41} + 43'd1) : {2'b0, m41};
      psum  = {{11{cur_p[31]}}, cur_p} + vt;
      ad    = psum[42] ? (~psum + 43'd1) : psum;

      acc     = sum_ff + {1'b0, mul_p};
      ev_done = 1'b0;
      ev_oor  = 1'b0;
      if (state_ff == S_EVAL) begin
         if (ph_ff == 3'd3 && ad_ff > {11'b0, safe_ff}) begin
            ev_done = 1'b1;
            ev_oor  = 1'b1;
         end else if (ph_ff == 3'd4) begin
            if (acc[64]) begin
               ev_done = 1'b1;
               ev_oor  = 1'b1;
            end else if (ax_ff == 2'd2) begin
               ev_done = 1'b1;
               ev_oor  = acc[63:0] > ss_ff;
            end
         end
      end

      div_start = (state_ff == S_DIV) && (vv_ff > VSQ_EPS) && (neg_ff > pos_ff);
      trial     = g_ff | (TIME_BITS'(1) << bis_ff);

      ht64     = 64'(ht_ff);
      ht32     = (ht64[63:32] != 32'd0) ? 32'hFFFF_FFFF : ht64[31:0];
      upd      = hit_ff && (!found_ff || etime_ff > ht32);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_CPA;
         rsp_valid_ff <= 1'b0;
         safe_ff      <= '0;
         found_ff     <= 1'b0;
         etime_ff     <= '0;
         efirst_ff    <= '0;
         esecond_ff   <= '0;
      end else begin
         if (csr_write) begin
            safe_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_item;
                  cnt_ff   <= '0;
                  vv_ff    <= '0;
                  pos_ff   <= '0;
                  neg_ff   <= '0;
                  state_ff <= S_DOT;
               end
            end
            S_DOT: begin
               pvs_ff <= cur_p[31] ^ cur_v[31];
               if (cnt_ff != 3'd0) begin
                  if (op < 3'd3) begin
                     vv_ff <= vv_ff + mul_p;
                  end else if (op < 3'd6) begin
                     if (pvs_ff) begin
                        neg_ff <= neg_ff + mul_p;
                     end else begin
                        pos_ff <= pos_ff + mul_p;
                     end
                  end else begin
                     ss_ff <= mul_p;
                  end
               end
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_start) begin
                  state_ff <= S_DIVW;
               end else begin
                  tc_ff    <= '0;
                  t_ff     <= '0;
                  mode_ff  <= M_CPA;
                  ax_ff    <= '0;
                  ph_ff    <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_EVAL;
               end
            end
            S_DIVW: begin
               if (div_done) begin
                  tc_ff    <= div_q;
                  t_ff     <= div_q;
                  mode_ff  <= M_CPA;
                  ax_ff    <= '0;
                  ph_ff    <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd1) begin
                  lo_ff <= mul_p;
               end
               if (ph_ff == 3'd2) begin
                  ad_ff <= ad;
               end
               if (ph_ff == 3'd4 && !ev_done) begin
                  sum_ff <= acc;
                  ax_ff  <= ax_ff + 2'd1;
                  ph_ff  <= '0;
               end
               if (ev_done) begin
                  ax_ff  <= '0;
                  ph_ff  <= '0;
                  sum_ff <= '0;
                  case (mode_ff)
                     M_CPA: begin
                        if (ev_oor) begin
                           hit_ff   <= 1'b0;
                           ht_ff    <= '0;
                           state_ff <= S_FIN;
                        end else begin
                           hit_ff  <= 1'b1;
                           t_ff    <= '0;
                           mode_ff <= M_ZERO;
                        end
                     end
                     M_ZERO: begin
                        if (!ev_oor) begin
                           ht_ff    <= '0;
                           state_ff <= S_FIN;
                        end else begin
                           g_ff     <= '0;
                           bis_ff   <= BW'(TIME_BITS - 1);
                           state_ff <= S_BIS;
                        end
                     end
                     default: begin
                        if (ev_oor) begin
                           g_ff <= t_ff;
                        end
                        if (bis_ff == '0) begin
                           ht_ff    <= (ev_oor ? t_ff : g_ff) + TIME_BITS'(1);
                           state_ff <= S_FIN;
                        end else begin
                           bis_ff   <= bis_ff - BW'(1);
                           state_ff <= S_BIS;
                        end
                     end
                  endcase
               end
            end
            S_BIS: begin
               if (trial < tc_ff) begin
                  t_ff     <= trial;
                  mode_ff  <= M_BIS;
                  state_ff <= S_EVAL;
               end else if (bis_ff == '0) begin
                  ht_ff    <= g_ff + TIME_BITS'(1);
                  state_ff <= S_FIN;
               end else begin
                  bis_ff <= bis_ff - BW'(1);
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.pair_hit       <= hit_ff;
                  rsp_ff.pair_time      <= hit_ff ? ht32 : 32'd0;
                  rsp_ff.summary_valid  <= item_ff.last_pair;
                  rsp_ff.alarm          <= found_ff || upd;
                  rsp_ff.best_time      <= upd ? ht32 : etime_ff;
                  rsp_ff.best_first     <= upd ? item_ff.first_index : efirst_ff;
                  rsp_ff.best_second    <= upd ? item_ff.second_index : esecond_ff;
                  if (item_ff.last_pair) begin
                     found_ff   <= 1'b0;
                     etime_ff   <= '0;
                     efirst_ff  <= '0;
                     esecond_ff <= '0;
                  end else if (upd) begin
                     found_ff   <= 1'b1;
                     etime_ff   <= ht32;
                     efirst_ff  <= item_ff.first_index;
                     esecond_ff <= item_ff.second_index;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_miss_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.pair_hit |-> rsp_item.pair_time == 32'd0)
      else $error("pair_time set on a miss");

   a_hit_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.pair_hit |-> rsp_item.alarm)
      else $error("hit without alarm");

   a_best_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.alarm |->
         rsp_item.best_time == 32'd0 && rsp_item.best_first == '0
         && rsp_item.best_second == '0)
      else $error("best fields set without alarm");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_item.summary_valid |-> !found_ff)
      else $error("minimum not cleared after last item");
endmodule
`default_nettype wire
